// ----- design/ipc_pkg.sv -----
// Shared types and constants for the IP address classifier.
package ipc_pkg;

   localparam int AddrWidth   = 64;
   localparam int ClassWidth  = 4;
   localparam int PrefixWidth = 8;
   localparam int IndexWidth  = 8;

   localparam logic [ClassWidth-1:0] CLASS_NONE    = 4'd0;
   localparam logic [ClassWidth-1:0] CLASS_RFC1918 = 4'd1;
   localparam logic [ClassWidth-1:0] CLASS_RFC2544 = 4'd2;
   localparam logic [ClassWidth-1:0] CLASS_RFC6598 = 4'd3;
   localparam logic [ClassWidth-1:0] CLASS_RFC5737 = 4'd4;
   localparam logic [ClassWidth-1:0] CLASS_RFC3927 = 4'd5;
   localparam logic [ClassWidth-1:0] CLASS_RFC3849 = 4'd6;
   localparam logic [ClassWidth-1:0] CLASS_RFC3964 = 4'd7;
   localparam logic [ClassWidth-1:0] CLASS_RFC4193 = 4'd8;
   localparam logic [ClassWidth-1:0] CLASS_RFC4380 = 4'd9;
   localparam logic [ClassWidth-1:0] CLASS_RFC4843 = 4'd10;
   localparam logic [ClassWidth-1:0] CLASS_RFC4862 = 4'd11;
   localparam logic [ClassWidth-1:0] CLASS_RFC6052 = 4'd12;
   localparam logic [ClassWidth-1:0] CLASS_RFC6145 = 4'd13;

   localparam logic [IndexWidth-1:0] CSR_BASE_HI   = 8'd0;
   localparam logic [IndexWidth-1:0] CSR_BASE_LO   = 8'd1;
   localparam logic [IndexWidth-1:0] CSR_PREFIX    = 8'd2;
   localparam logic [IndexWidth-1:0] CSR_FAMILY_V6 = 8'd3;

   typedef struct packed {
      logic [AddrWidth-1:0] addr_hi;
      logic [AddrWidth-1:0] addr_lo;
      logic                 addr_is_v6;
   } addr_type;

   typedef struct packed {
      logic [ClassWidth-1:0] reservation_class;
      logic                  reserved;
      logic                  routable;
      logic                  loopback;
      logic                  multicast;
      logic                  is_valid_addr;
   } flags_type;

   typedef struct packed {
      logic [AddrWidth-1:0]   base_hi;
      logic [AddrWidth-1:0]   base_lo;
      logic [PrefixWidth-1:0] prefix_len;
      logic                   family_v6;
   } subnet_type;

endpackage

// ----- design/ipc_range_class.sv -----
// Reserved-range class and address flags for one IPv4 or IPv6 word.
module ipc_range_class (
   input  ipc_pkg::addr_type  addr,
   output ipc_pkg::flags_type flags
);
   import ipc_pkg::*;

   logic [31:0]           a4;
   logic [7:0]            b0;
   logic [7:0]            b1;
   logic [7:0]            b2;
   logic [31:0]           top32;
   logic [15:0]           top16;
   logic [7:0]            h0;
   logic [ClassWidth-1:0] class_v4;
   logic [ClassWidth-1:0] class_v6;
   logic [ClassWidth-1:0] cls;
   logic                  valid;
   logic                  loop;
   logic                  mcast;
   logic                  blocked;

   assign a4    = addr.addr_lo[31:0];
   assign b0    = a4[31:24];
   assign b1    = a4[23:16];
   assign b2    = a4[15:8];
   assign top32 = addr.addr_hi[63:32];
   assign top16 = addr.addr_hi[63:48];
   assign h0    = addr.addr_hi[63:56];

   always_comb begin
      class_v4 = CLASS_NONE;
      if (b0 == 8'd10 || (b0 == 8'd172 && b1 >= 8'd16 && b1 <= 8'd31) ||
          (b0 == 8'd192 && b1 == 8'd168)) begin
         class_v4 = CLASS_RFC1918;
      end
      if (b0 == 8'd198 && (b1 == 8'd18 || b1 == 8'd19)) begin
         class_v4 = CLASS_RFC2544;
      end
      if (b0 == 8'd100 && b1 >= 8'd64 && b1 <= 8'd127) begin
         class_v4 = CLASS_RFC6598;
      end
      if ((b0 == 8'd192 && b1 == 8'd0 && b2 == 8'd2) ||
          (b0 == 8'd198 && b1 == 8'd51 && b2 == 8'd100) ||
          (b0 == 8'd203 && b1 == 8'd0 && b2 == 8'd113)) begin
         class_v4 = CLASS_RFC5737;
      end
      if (b0 == 8'd169 && b1 == 8'd254) begin
         class_v4 = CLASS_RFC3927;
      end
   end

   always_comb begin
      class_v6 = CLASS_NONE;
      if (top32 == 32'h2001_0DB8) class_v6 = CLASS_RFC3849;
      if (top16 == 16'h2002) class_v6 = CLASS_RFC3964;
      if (h0 == 8'hFC || h0 == 8'hFD) class_v6 = CLASS_RFC4193;
      if (top32 == 32'h2001_0000) class_v6 = CLASS_RFC4380;
      if ((top32 & 32'hFFFF_FFF0) == 32'h2001_0010) class_v6 = CLASS_RFC4843;
      if (top16 == 16'hFE80) class_v6 = CLASS_RFC4862;
      if (top32 == 32'h0064_FF9B) class_v6 = CLASS_RFC6052;
      if (addr.addr_hi == 64'h0000_FFFF_0000_0000 && addr.addr_lo == 64'd0) begin
         class_v6 = CLASS_RFC6145;
      end
   end

   always_comb begin
      if (addr.addr_is_v6) begin
         valid = (addr.addr_hi | addr.addr_lo) != 64'd0;
         loop  = addr.addr_hi == 64'd0 && addr.addr_lo == 64'd1;
         mcast = h0 == 8'hFF;
         cls   = valid ? class_v6 : CLASS_NONE;
      end else begin
         valid = a4 != 32'd0;
         loop  = b0 == 8'd127;
         mcast = a4[31:28] == 4'hE;
         cls   = valid ? class_v4 : CLASS_NONE;
      end
   end

   always_comb begin
      case (cls)
         CLASS_RFC1918, CLASS_RFC2544, CLASS_RFC6598, CLASS_RFC5737, CLASS_RFC3927,
         CLASS_RFC3849, CLASS_RFC4193, CLASS_RFC4843, CLASS_RFC4862: blocked = 1'b1;
         default: blocked = 1'b0;
      endcase
   end

   assign flags.reservation_class = cls;
   assign flags.reserved          = cls != CLASS_NONE;
   assign flags.routable          = valid && !loop && !blocked;
   assign flags.loopback          = loop;
   assign flags.multicast         = mcast;
   assign flags.is_valid_addr     = valid;

endmodule

// ----- design/ipc_subnet_match.sv -----
// Membership test of one address word against the configured subnet.
module ipc_subnet_match (
   input  ipc_pkg::addr_type   addr,
   input  ipc_pkg::subnet_type subnet,
   output logic                in_subnet
);
   import ipc_pkg::*;

   logic [31:0]              mask_v4;
   logic [2*AddrWidth-1:0]   mask_v6;
   logic [PrefixWidth-1:0]   shift_v4;
   logic [PrefixWidth-1:0]   shift_v6;
   logic [2*AddrWidth-1:0]   addr_v6;
   logic [2*AddrWidth-1:0]   base_v6;
   logic                     ok_v4;
   logic                     ok_v6;

   assign shift_v4 = 8'd32 - subnet.prefix_len;
   assign shift_v6 = 8'd128 - subnet.prefix_len;
   assign mask_v4  = {32{1'b1}} << shift_v4;
   assign mask_v6  = {(2*AddrWidth){1'b1}} << shift_v6;
   assign addr_v6  = {addr.addr_hi, addr.addr_lo};
   assign base_v6  = {subnet.base_hi, subnet.base_lo};

   assign ok_v4 = subnet.base_lo[31:0] != 32'd0 && subnet.prefix_len >= 8'd1 &&
                  subnet.prefix_len <= 8'd32 &&
                  (addr.addr_lo[31:0] & mask_v4) == subnet.base_lo[31:0];
   assign ok_v6 = base_v6 != '0 && subnet.prefix_len >= 8'd1 &&
                  subnet.prefix_len <= 8'd128 && (addr_v6 & mask_v6) == base_v6;

   always_comb begin
      if (addr.addr_is_v6 != subnet.family_v6) begin
         in_subnet = 1'b0;
      end else if (addr.addr_is_v6) begin
         in_subnet = ok_v6;
      end else begin
         in_subnet = ok_v4;
      end
   end

endmodule

// ----- design/ip_address_classifier.sv -----
// Top level of the IP address classifier: word register, classify, result register.
// A word is held in the word register, classified, and strobed on rsp_valid from the result register.
// Throughput: one word per cycle; busy stays low, so start may be held every cycle.
// The rate is set by the single-pass classify and subnet compare between two registers.
// Reset (synchronous, active high) drops any word in flight and clears the subnet registers.
// Results are shown for one cycle on rsp_valid; the receiver cannot stall.
module ip_address_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ipc_pkg::AddrWidth-1:0]      req_addr_hi,
   input  logic [ipc_pkg::AddrWidth-1:0]      req_addr_lo,
   input  logic                               req_addr_is_v6,
   output logic                               rsp_valid,
   output logic [ipc_pkg::ClassWidth-1:0]     rsp_reservation_class,
   output logic                               rsp_reserved,
   output logic                               rsp_routable,
   output logic                               rsp_loopback,
   output logic                               rsp_multicast,
   output logic                               rsp_is_valid_addr,
   output logic                               rsp_in_subnet,
   input  logic                               csr_we,
   input  logic [ipc_pkg::IndexWidth-1:0]     csr_index,
   input  logic [ipc_pkg::AddrWidth-1:0]      csr_wdata
);
   import ipc_pkg::*;

   logic       req_valid_ff;
   addr_type   req_addr_ff;
   subnet_type subnet_ff;
   subnet_type subnet_in;
   flags_type  flags;
   logic       subnet_hit;
   logic       rsp_valid_ff;
   flags_type  rsp_flags_ff;
   logic       rsp_in_subnet_ff;
   logic       rsp_in_subnet_in;

   assign busy = 1'b0;

   always_comb begin
      subnet_in = subnet_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BASE_HI:   subnet_in.base_hi    = csr_wdata;
            CSR_BASE_LO:   subnet_in.base_lo    = csr_wdata;
            CSR_PREFIX:    subnet_in.prefix_len = csr_wdata[PrefixWidth-1:0];
            CSR_FAMILY_V6: subnet_in.family_v6  = csr_wdata[0];
            default:       subnet_in = subnet_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         subnet_ff <= '0;
      end else begin
         subnet_ff <= subnet_in;
      end
   end

   // hold the word
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_addr_ff.addr_hi    <= req_addr_hi;
         req_addr_ff.addr_lo    <= req_addr_lo;
         req_addr_ff.addr_is_v6 <= req_addr_is_v6;
      end
   end

   ipc_range_class u_range_class (
      .addr  (req_addr_ff),
      .flags (flags)
   );

   ipc_subnet_match u_subnet_match (
      .addr      (req_addr_ff),
      .subnet    (subnet_ff),
      .in_subnet (subnet_hit)
   );

   assign rsp_in_subnet_in = flags.is_valid_addr && !flags.loopback && subnet_hit;

   // advance to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_flags_ff     <= flags;
         rsp_in_subnet_ff <= rsp_in_subnet_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_reservation_class = rsp_flags_ff.reservation_class;
   assign rsp_reserved          = rsp_flags_ff.reserved;
   assign rsp_routable          = rsp_flags_ff.routable;
   assign rsp_loopback          = rsp_flags_ff.loopback;
   assign rsp_multicast         = rsp_flags_ff.multicast;
   assign rsp_is_valid_addr     = rsp_flags_ff.is_valid_addr;
   assign rsp_in_subnet         = rsp_in_subnet_ff;

endmodule
